@@ rtl/cqsi_pkg.sv @@
package cqsi_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CAP_W      = 5;
	localparam int REQ_W      = 3;
	localparam int STAT_W     = 3;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] data_t;

	localparam logic [REQ_W-1:0] REQ_ENQ    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DEQ    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd3;
	localparam logic [REQ_W-1:0] REQ_INVERT = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_TOOFEW   = 3'd4;

	// zero acts as one, anything past the store size acts as the store size
	function automatic cnt_t cap_eff(input logic [CAP_W-1:0] v);
		cnt_t r;
		if (v == '0) begin
			r = cnt_t'(1);
		end else if (int'(v) > DEPTH) begin
			r = cnt_t'(DEPTH);
		end else begin
			r = cnt_t'(v);
		end
		return r;
	endfunction

endpackage

@@ rtl/cqsi_ring_mem.sv @@
module cqsi_ring_mem (
	input  logic                 clk,
	input  logic                 we,
	input  cqsi_pkg::idx_t       waddr,
	input  cqsi_pkg::data_t      wdata,
	input  cqsi_pkg::idx_t       raddr,
	output cqsi_pkg::data_t      rdata
);

	cqsi_pkg::data_t mem [cqsi_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/cqsi_slot_unit.sv @@
module cqsi_slot_unit (
	input  cqsi_pkg::idx_t base,
	input  cqsi_pkg::cnt_t offset,
	input  cqsi_pkg::cnt_t cap,
	output cqsi_pkg::idx_t slot
);

	logic [cqsi_pkg::CNT_W:0] sum;
	logic [cqsi_pkg::CNT_W:0] wrapped;

	// base < cap and offset <= cap, so one conditional subtract wraps it
	always_comb begin
		sum = {2'b00, base} + {1'b0, offset};
		if (sum >= {1'b0, cap}) begin
			wrapped = sum - {1'b0, cap};
		end else begin
			wrapped = sum;
		end
		slot = wrapped[cqsi_pkg::IDX_W-1:0];
	end

endmodule

@@ rtl/circular_queue_with_search_invert.sv @@
// channel | direction | handshake             | payload
// cfg     | in        | cfg_valid / cfg_ready | capacity_in_use
// in      | in        | in_valid / in_ready   | req_type, data_in
// out     | out       | out_valid / out_ready | status, data_out, found_position, entry_count
//
// Per request: enqueue writes in S_EXEC, dequeue and peek read via S_RD_WAIT unless empty,
// search scans to a match or the last entry, invert swaps end pairs via the S_INV_* states.
// The ring memory's registered read and the one shared slot adder set these steps.
// Reset (arst_n low) empties the queue and sets capacity to 16.
// A finished result waits in the output register; the next request is taken meanwhile.
module circular_queue_with_search_invert (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cqsi_pkg::CAP_W-1:0]          capacity_in_use,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [cqsi_pkg::REQ_W-1:0]          req_type,
	input  logic signed [cqsi_pkg::DATA_WIDTH-1:0] data_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cqsi_pkg::STAT_W-1:0]         status,
	output logic signed [cqsi_pkg::DATA_WIDTH-1:0] data_out,
	output logic [cqsi_pkg::IDX_W-1:0]          found_position,
	output logic [cqsi_pkg::CNT_W-1:0]          entry_count
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EXEC    = 4'd1;
	localparam logic [3:0] S_RD_WAIT = 4'd2;
	localparam logic [3:0] S_SRCH    = 4'd3;
	localparam logic [3:0] S_INV_RA  = 4'd4;
	localparam logic [3:0] S_INV_RB  = 4'd5;
	localparam logic [3:0] S_INV_WA  = 4'd6;
	localparam logic [3:0] S_INV_WB  = 4'd7;
	localparam logic [3:0] S_FIN     = 4'd8;

	logic [3:0]                     state_q;
	logic [cqsi_pkg::REQ_W-1:0]     req_q;
	cqsi_pkg::data_t                key_q;
	cqsi_pkg::cnt_t                 cap_q;
	cqsi_pkg::idx_t                 head_q;
	cqsi_pkg::idx_t                 tail_q;
	cqsi_pkg::cnt_t                 held_q;
	cqsi_pkg::idx_t                 idx_q;
	cqsi_pkg::idx_t                 lo_q;
	cqsi_pkg::idx_t                 hi_q;
	cqsi_pkg::idx_t                 addr_a_q;
	cqsi_pkg::idx_t                 addr_b_q;
	cqsi_pkg::data_t                tmp_q;
	logic [cqsi_pkg::STAT_W-1:0]    res_status_q;
	cqsi_pkg::data_t                res_data_q;
	cqsi_pkg::idx_t                 res_pos_q;
	logic                           out_valid_q;

	cqsi_pkg::idx_t  slot_base;
	cqsi_pkg::cnt_t  slot_off;
	cqsi_pkg::idx_t  slot;
	logic            mem_we;
	cqsi_pkg::idx_t  mem_waddr;
	cqsi_pkg::data_t mem_wdata;
	cqsi_pkg::idx_t  mem_raddr;
	cqsi_pkg::data_t mem_rdata;

	logic            cfg_fire;
	logic            in_fire;
	logic            out_load;
	logic            is_full;
	logic            match;
	logic            last;
	logic            inv_more;
	cqsi_pkg::cnt_t  cap_new;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign cap_new   = cqsi_pkg::cap_eff(capacity_in_use);

	assign is_full  = (held_q >= cap_q);
	assign match    = (mem_rdata == key_q);
	assign last     = ((cqsi_pkg::cnt_t'(idx_q) + cqsi_pkg::cnt_t'(1)) == held_q);
	assign inv_more = ((cqsi_pkg::cnt_t'(lo_q) + cqsi_pkg::cnt_t'(2)) < cqsi_pkg::cnt_t'(hi_q));

	cqsi_slot_unit u_slot (
		.base   (slot_base),
		.offset (slot_off),
		.cap    (cap_q),
		.slot   (slot)
	);

	cqsi_ring_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		slot_base = head_q;
		slot_off  = '0;
		mem_we    = 1'b0;
		mem_waddr = slot;
		mem_wdata = key_q;
		mem_raddr = head_q;
		unique case (state_q)
			S_EXEC: begin
				if (req_q == cqsi_pkg::REQ_ENQ) begin
					slot_base = tail_q;
					slot_off  = cqsi_pkg::cnt_t'(1);
					mem_we    = !is_full;
				end else if (req_q == cqsi_pkg::REQ_SEARCH) begin
					mem_raddr = slot;
				end
			end
			S_RD_WAIT: begin
				slot_off = cqsi_pkg::cnt_t'(1);
			end
			S_SRCH: begin
				slot_off  = cqsi_pkg::cnt_t'(idx_q) + cqsi_pkg::cnt_t'(1);
				mem_raddr = slot;
			end
			S_INV_RA: begin
				slot_off  = cqsi_pkg::cnt_t'(lo_q);
				mem_raddr = slot;
			end
			S_INV_RB: begin
				slot_off  = cqsi_pkg::cnt_t'(hi_q);
				mem_raddr = slot;
			end
			S_INV_WA: begin
				mem_we    = 1'b1;
				mem_waddr = addr_a_q;
				mem_wdata = mem_rdata;
			end
			S_INV_WB: begin
				mem_we    = 1'b1;
				mem_waddr = addr_b_q;
				mem_wdata = tmp_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= cqsi_pkg::cnt_t'(cqsi_pkg::DEPTH);
			head_q      <= '0;
			tail_q      <= cqsi_pkg::idx_t'(cqsi_pkg::DEPTH - 1);
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_fire) begin
						cap_q  <= cap_new;
						head_q <= '0;
						tail_q <= cqsi_pkg::idx_t'(cap_new - cqsi_pkg::cnt_t'(1));
						held_q <= '0;
					end else if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (req_q)
						cqsi_pkg::REQ_ENQ: begin
							if (!is_full) begin
								tail_q <= slot;
								held_q <= held_q + cqsi_pkg::cnt_t'(1);
							end
							state_q <= S_FIN;
						end
						cqsi_pkg::REQ_DEQ, cqsi_pkg::REQ_PEEK: begin
							state_q <= (held_q == '0) ? S_FIN : S_RD_WAIT;
						end
						cqsi_pkg::REQ_SEARCH: begin
							state_q <= (held_q == '0) ? S_FIN : S_SRCH;
						end
						cqsi_pkg::REQ_INVERT: begin
							state_q <= (held_q < cqsi_pkg::cnt_t'(2)) ? S_FIN : S_INV_RA;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_RD_WAIT: begin
					if (req_q == cqsi_pkg::REQ_DEQ) begin
						head_q <= slot;
						held_q <= held_q - cqsi_pkg::cnt_t'(1);
					end
					state_q <= S_FIN;
				end
				S_SRCH: begin
					if (match || last) begin
						state_q <= S_FIN;
					end
				end
				S_INV_RA: state_q <= S_INV_RB;
				S_INV_RB: state_q <= S_INV_WA;
				S_INV_WA: state_q <= S_INV_WB;
				S_INV_WB: state_q <= inv_more ? S_INV_RA : S_FIN;
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					req_q        <= req_type;
					key_q        <= data_in;
					res_status_q <= cqsi_pkg::ST_OK;
					res_data_q   <= '0;
					res_pos_q    <= '0;
				end
			end
			S_EXEC: begin
				case (req_q)
					cqsi_pkg::REQ_ENQ: begin
						if (is_full) begin
							res_status_q <= cqsi_pkg::ST_FULL;
						end
					end
					cqsi_pkg::REQ_DEQ, cqsi_pkg::REQ_PEEK: begin
						if (held_q == '0) begin
							res_status_q <= cqsi_pkg::ST_EMPTY;
						end
					end
					cqsi_pkg::REQ_SEARCH: begin
						res_status_q <= cqsi_pkg::ST_NOTFOUND;
						idx_q        <= '0;
					end
					cqsi_pkg::REQ_INVERT: begin
						if (held_q < cqsi_pkg::cnt_t'(2)) begin
							res_status_q <= cqsi_pkg::ST_TOOFEW;
						end
						lo_q <= '0;
						hi_q <= cqsi_pkg::idx_t'(held_q - cqsi_pkg::cnt_t'(1));
					end
					default: begin
					end
				endcase
			end
			S_RD_WAIT: res_data_q <= mem_rdata;
			S_SRCH: begin
				if (match) begin
					res_status_q <= cqsi_pkg::ST_OK;
					res_pos_q    <= idx_q;
				end
				idx_q <= idx_q + cqsi_pkg::idx_t'(1);
			end
			S_INV_RA: addr_a_q <= slot;
			S_INV_RB: begin
				tmp_q    <= mem_rdata;
				addr_b_q <= slot;
			end
			S_INV_WB: begin
				lo_q <= lo_q + cqsi_pkg::idx_t'(1);
				hi_q <= hi_q - cqsi_pkg::idx_t'(1);
			end
			S_FIN: begin
				if (out_load) begin
					status         <= res_status_q;
					data_out       <= res_data_q;
					found_position <= res_pos_q;
					entry_count    <= held_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/cqsi_checker.sv @@
module cqsi_assertions (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [cqsi_pkg::STAT_W-1:0]            status,
	input logic signed [cqsi_pkg::DATA_WIDTH-1:0] data_out,
	input logic [cqsi_pkg::IDX_W-1:0]             found_position,
	input logic [cqsi_pkg::CNT_W-1:0]             entry_count
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_out)
			&& $stable(found_position) && $stable(entry_count))
		else $error("result changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cqsi_pkg::ST_EMPTY |-> entry_count == '0 && data_out == '0)
		else $error("empty status with entries or data");

	a_toofew: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cqsi_pkg::ST_TOOFEW |-> entry_count < 2)
		else $error("invert refused with two or more entries");

	a_notfound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == cqsi_pkg::ST_NOTFOUND || status == cqsi_pkg::ST_FULL)
			|-> found_position == '0 && data_out == '0)
		else $error("failed request carries data or position");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= cqsi_pkg::CNT_W'(cqsi_pkg::DEPTH))
		else $error("entry count beyond store size");

endmodule

bind circular_queue_with_search_invert cqsi_assertions u_cqsi_assertions (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.data_out       (data_out),
	.found_position (found_position),
	.entry_count    (entry_count)
);

@@ bench/cqsi_checker.sv @@
module cqsi_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [cqsi_pkg::CAP_W-1:0]             capacity_in_use,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic [cqsi_pkg::REQ_W-1:0]             req_type,
	input  logic signed [cqsi_pkg::DATA_WIDTH-1:0] data_in,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic [cqsi_pkg::STAT_W-1:0]            status,
	input  logic signed [cqsi_pkg::DATA_WIDTH-1:0] data_out,
	input  logic [cqsi_pkg::IDX_W-1:0]             found_position,
	input  logic [cqsi_pkg::CNT_W-1:0]             entry_count,
	output int                                     fail_count,
	output int                                     pending
);

	typedef struct packed {
		logic [cqsi_pkg::STAT_W-1:0] st;
		cqsi_pkg::data_t             word;
		cqsi_pkg::idx_t              pos;
		cqsi_pkg::cnt_t              cnt;
	} queue_result_t;

	cqsi_pkg::data_t            ring_mem [cqsi_pkg::DEPTH];
	int                         head_ptr;
	int                         tail_ptr;
	int                         held;
	logic [cqsi_pkg::CAP_W-1:0] cap_setting;
	queue_result_t              awaited_results [$];

	function automatic int ring_len();
		int c;
		c = int'(cap_setting);
		if (c == 0) c = 1;
		if (c > cqsi_pkg::DEPTH) c = cqsi_pkg::DEPTH;
		return c;
	endfunction

	function automatic void empty_ring();
		head_ptr = 0;
		tail_ptr = ring_len() - 1;
		held = 0;
	endfunction

	function automatic queue_result_t apply_request(input logic [cqsi_pkg::REQ_W-1:0] rq,
		input cqsi_pkg::data_t w);
		queue_result_t r;
		int c;
		int i;
		int lo;
		int hi;
		int a;
		int b;
		bit hit;
		cqsi_pkg::data_t t;
		c = ring_len();
		r = '0;
		case (rq)
			cqsi_pkg::REQ_ENQ: begin
				if (held >= c) begin
					r.st = cqsi_pkg::ST_FULL;
				end else begin
					tail_ptr = (tail_ptr + 1) % c;
					ring_mem[tail_ptr] = w;
					held++;
				end
			end
			cqsi_pkg::REQ_DEQ, cqsi_pkg::REQ_PEEK: begin
				if (held == 0) begin
					r.st = cqsi_pkg::ST_EMPTY;
				end else begin
					r.word = ring_mem[head_ptr];
					if (rq == cqsi_pkg::REQ_DEQ) begin
						head_ptr = (head_ptr + 1) % c;
						held--;
					end
				end
			end
			cqsi_pkg::REQ_SEARCH: begin
				r.st = cqsi_pkg::ST_NOTFOUND;
				hit = 0;
				for (i = 0; i < held; i++) begin
					if (!hit && ring_mem[(head_ptr + i) % c] == w) begin
						hit = 1;
						r.st = cqsi_pkg::ST_OK;
						r.pos = cqsi_pkg::idx_t'(i);
					end
				end
			end
			cqsi_pkg::REQ_INVERT: begin
				if (held < 2) begin
					r.st = cqsi_pkg::ST_TOOFEW;
				end else begin
					lo = 0;
					hi = held - 1;
					while (lo < hi) begin
						a = (head_ptr + lo) % c;
						b = (head_ptr + hi) % c;
						t = ring_mem[a];
						ring_mem[a] = ring_mem[b];
						ring_mem[b] = t;
						lo++;
						hi--;
					end
				end
			end
			default: begin
			end
		endcase
		r.cnt = cqsi_pkg::cnt_t'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			for (int k = 0; k < cqsi_pkg::DEPTH; k++) ring_mem[k] = '0;
			cap_setting = cqsi_pkg::CAP_W'(cqsi_pkg::DEPTH);
			empty_ring();
			awaited_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_setting = capacity_in_use;
				empty_ring();
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result transfer: status %0d data_out %0d", status, data_out);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						fail_count++;
					end
					if (data_out !== want.word) begin
						$error("data_out: expected %0d, actual %0d",
							$signed(want.word), data_out);
						fail_count++;
					end
					if (found_position !== want.pos) begin
						$error("found_position: expected %0d, actual %0d",
							want.pos, found_position);
						fail_count++;
					end
					if (entry_count !== want.cnt) begin
						$error("entry_count: expected %0d, actual %0d", want.cnt, entry_count);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				awaited_results.push_back(apply_request(req_type, data_in));
			end
			pending = awaited_results.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
module tb_top;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} burst_mode_t;

	logic                                   clk = 0;
	logic                                   arst_n = 0;
	logic                                   cfg_valid = 0;
	logic                                   cfg_ready;
	logic [cqsi_pkg::CAP_W-1:0]             capacity_in_use = '0;
	logic                                   in_valid = 0;
	logic                                   in_ready;
	logic [cqsi_pkg::REQ_W-1:0]             req_type = cqsi_pkg::REQ_ENQ;
	logic signed [cqsi_pkg::DATA_WIDTH-1:0] data_in = '0;
	logic                                   out_valid;
	logic                                   out_ready = 0;
	logic [cqsi_pkg::STAT_W-1:0]            status;
	logic signed [cqsi_pkg::DATA_WIDTH-1:0] data_out;
	logic [cqsi_pkg::IDX_W-1:0]             found_position;
	logic [cqsi_pkg::CNT_W-1:0]             entry_count;
	int                                     fail_count;
	int                                     pending;

	bit              pressure_go = 0;
	bit              pressure_done = 0;
	cqsi_pkg::data_t recent_words [$];

	always #10 clk = ~clk;

	circular_queue_with_search_invert dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity_in_use(capacity_in_use),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.data_in        (data_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.data_out       (data_out),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	cqsi_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity_in_use(capacity_in_use),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.data_in        (data_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.data_out       (data_out),
		.found_position (found_position),
		.entry_count    (entry_count),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(30, 4);
	endfunction

	function automatic cqsi_pkg::data_t pick_word();
		int r;
		r = $urandom_range(99);
		if (r < 12) begin
			case ($urandom_range(3))
				0: return {1'b1, {(cqsi_pkg::DATA_WIDTH-1){1'b0}}};
				1: return {1'b0, {(cqsi_pkg::DATA_WIDTH-1){1'b1}}};
				2: return '0;
				default: return '1;
			endcase
		end
		if (r < 35) return cqsi_pkg::data_t'($urandom_range(7));
		return cqsi_pkg::data_t'($urandom);
	endfunction

	function automatic logic [cqsi_pkg::REQ_W-1:0] pick_req(input burst_mode_t m);
		int r;
		int w_enq;
		int w_deq;
		r = $urandom_range(99);
		case (m)
			MODE_FILL:  begin w_enq = 65; w_deq = 10; end
			MODE_DRAIN: begin w_enq = 10; w_deq = 60; end
			default:    begin w_enq = 35; w_deq = 25; end
		endcase
		if (r < 3) return cqsi_pkg::REQ_INVERT + cqsi_pkg::REQ_W'($urandom_range(3, 1));
		r = r - 3;
		if (r < w_enq) return cqsi_pkg::REQ_ENQ;
		r = r - w_enq;
		if (r < w_deq) return cqsi_pkg::REQ_DEQ;
		r = r - w_deq;
		if (r < 8) return cqsi_pkg::REQ_PEEK;
		if (r < 20) return cqsi_pkg::REQ_INVERT;
		return cqsi_pkg::REQ_SEARCH;
	endfunction

	// one transfer on the request channel; leaves valid high when no gap follows
	task automatic send_req(input logic [cqsi_pkg::REQ_W-1:0] rq, input cqsi_pkg::data_t w,
		input int gap);
		in_valid <= 1;
		req_type <= rq;
		data_in  <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (rq == cqsi_pkg::REQ_ENQ) begin
			recent_words.push_back(w);
			if (recent_words.size() > 16) void'(recent_words.pop_front());
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_capacity(input logic [cqsi_pkg::CAP_W-1:0] v);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid       <= 1;
		capacity_in_use <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic cqsi_pkg::data_t search_key();
		if (recent_words.size() != 0 && $urandom_range(99) < 60)
			return recent_words[$urandom_range(recent_words.size() - 1)];
		return pick_word();
	endfunction

	// receiver side
	initial begin
		int on_len;
		int off_len;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (pressure_go && !pressure_done) begin
				out_ready <= 0;
				repeat (400) @(negedge clk);
				pressure_done = 1;
			end else begin
				out_ready <= 1;
				on_len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
				repeat (on_len) @(negedge clk);
				off_len = pick_gap();
				if (off_len > 0) begin
					out_ready <= 0;
					repeat (off_len) @(negedge clk);
				end
			end
		end
	end

	initial begin
		logic [cqsi_pkg::CAP_W-1:0] cap_plan [10];
		burst_mode_t                mode;
		logic [cqsi_pkg::REQ_W-1:0] rq;
		cqsi_pkg::data_t            w;
		int                         sent;
		int                         burst_len;
		bit                         gapless;
		cap_plan = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd17, 5'd3, 5'd16, 5'd9};
		cap_plan[7] = cqsi_pkg::CAP_W'($urandom_range(cqsi_pkg::DEPTH, 1));

		repeat (7) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: empty cases, extremes, duplicates, spare codes
		send_req(cqsi_pkg::REQ_DEQ,    '0, pick_gap());
		send_req(cqsi_pkg::REQ_PEEK,   '0, pick_gap());
		send_req(cqsi_pkg::REQ_SEARCH, '0, pick_gap());
		send_req(cqsi_pkg::REQ_INVERT, '0, pick_gap());
		send_req(cqsi_pkg::REQ_ENQ,    {1'b1, {(cqsi_pkg::DATA_WIDTH-1){1'b0}}}, pick_gap());
		send_req(cqsi_pkg::REQ_INVERT, '0, pick_gap());
		send_req(cqsi_pkg::REQ_SEARCH, {1'b1, {(cqsi_pkg::DATA_WIDTH-1){1'b0}}}, pick_gap());
		send_req(cqsi_pkg::REQ_ENQ,    {1'b0, {(cqsi_pkg::DATA_WIDTH-1){1'b1}}}, pick_gap());
		send_req(cqsi_pkg::REQ_ENQ,    '0, pick_gap());
		send_req(cqsi_pkg::REQ_ENQ,    '1, pick_gap());
		send_req(cqsi_pkg::REQ_ENQ,    {1'b0, {(cqsi_pkg::DATA_WIDTH-1){1'b1}}}, pick_gap());
		send_req(cqsi_pkg::REQ_SEARCH, {1'b0, {(cqsi_pkg::DATA_WIDTH-1){1'b1}}}, pick_gap());
		send_req(cqsi_pkg::REQ_SEARCH, cqsi_pkg::data_t'(12345), pick_gap());
		send_req(cqsi_pkg::REQ_INVERT, '0, pick_gap());
		send_req(cqsi_pkg::REQ_PEEK,   '0, pick_gap());
		send_req(cqsi_pkg::REQ_DEQ,    '0, pick_gap());
		send_req(cqsi_pkg::REQ_INVERT + cqsi_pkg::REQ_W'(1), '1, pick_gap());
		send_req(cqsi_pkg::REQ_INVERT + cqsi_pkg::REQ_W'(2), '1, pick_gap());
		send_req(cqsi_pkg::REQ_INVERT + cqsi_pkg::REQ_W'(3), '1, pick_gap());
		write_capacity(cqsi_pkg::CAP_W'(1));
		send_req(cqsi_pkg::REQ_ENQ,    cqsi_pkg::data_t'($urandom), pick_gap());
		send_req(cqsi_pkg::REQ_ENQ,    cqsi_pkg::data_t'($urandom), pick_gap());
		send_req(cqsi_pkg::REQ_INVERT, '0, pick_gap());
		send_req(cqsi_pkg::REQ_DEQ,    '0, pick_gap());
		send_req(cqsi_pkg::REQ_DEQ,    '0, pick_gap());

		for (int ph = 0; ph < 10; ph++) begin
			write_capacity(cap_plan[ph]);
			sent = 0;
			while (sent < 85) begin
				mode = burst_mode_t'($urandom_range(2));
				burst_len = $urandom_range(24, 8);
				gapless = ($urandom_range(3) == 0);
				if (ph == 0 && sent == 0) begin
					mode = MODE_FILL;
					burst_len = 40;
					gapless = 1;
					pressure_go = 1;
				end
				for (int k = 0; k < burst_len; k++) begin
					rq = pick_req(mode);
					w = (rq == cqsi_pkg::REQ_SEARCH) ? search_key() : pick_word();
					send_req(rq, w, gapless ? 0 : pick_gap());
				end
				sent += burst_len;
			end
		end

		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
rtl/cqsi_pkg.sv
rtl/cqsi_ring_mem.sv
rtl/cqsi_slot_unit.sv
rtl/circular_queue_with_search_invert.sv
rtl/cqsi_checker.sv
bench/cqsi_checker.sv
bench/tb_top.sv
